@@ design/btks_pkg.sv @@
`default_nettype none

package btks_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int REM_W     = 34;
    localparam int DIVISOR_W = 33;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] CONF_DIV_STEPS = 5'd15;

    localparam logic [15:0] CONF_ONE = 16'd32768;

    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE      = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASUREMENT_NOISE  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COVARIANCE = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPIRY_SPAN        = 4'd3;

    localparam logic [31:0] PROCESS_NOISE_RST      = 32'd65536;
    localparam logic [31:0] MEASUREMENT_NOISE_RST  = 32'd65536;
    localparam logic [31:0] INITIAL_COVARIANCE_RST = 32'd65536;
    localparam logic [31:0] EXPIRY_SPAN_RST        = 32'd1000000;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_AGE    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_GAIN,
        ST_AGE,
        ST_AGE_DIV,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [REM_W-1:0]     rem_init;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

`default_nettype wire

@@ design/box_track_kalman_smoother.sv @@
`default_nettype none

// channel  | direction | handshake            | payload
// s_       | in        | s_valid / s_ready    | operation, four measured coordinates, time_now
// m_       | out       | m_valid / m_ready    | four estimates, error_variance, confidence,
//          |           |                      | expired
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// start and unused operation: accept goes straight to the done state, which loads the result register
// update: runs the bit-serial gain divider and then five passes through the
// shared multiplier
// age check: up to 15 bit-serial confidence divider steps
// s_ready is high only when idle; a waiting result holds the sequencer in its
// final state. synchronous active-low reset, cfg_ready is always high

module box_track_kalman_smoother #(
    parameter int COORD_FRAC_BITS = btks_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_operation,
    input  wire logic signed [31:0]                  s_meas_left_x,
    input  wire logic signed [31:0]                  s_meas_left_y,
    input  wire logic signed [31:0]                  s_meas_right_x,
    input  wire logic signed [31:0]                  s_meas_right_y,
    input  wire logic [47:0]                         s_time_now,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [31:0]                       m_est_left_x,
    output logic signed [31:0]                       m_est_left_y,
    output logic signed [31:0]                       m_est_right_x,
    output logic signed [31:0]                       m_est_right_y,
    output logic [31:0]                              m_error_variance,
    output logic [15:0]                              m_confidence,
    output logic                                     m_expired,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [btks_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [31:0]                         cfg_data
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int QW = (F + 1 > 15) ? (F + 1) : 15;
    localparam int BW = F + 2;
    localparam int PW = btks_pkg::REM_W + BW;

    localparam logic [F:0]    K_ONE = {1'b1, {F{1'b0}}};
    localparam logic [PW-1:0] HALF  = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

    btks_pkg::state_t   state_reg, state_next;
    btks_pkg::op_t      op_reg;
    btks_pkg::div_req_t div_req;

    logic [31:0] q_reg, r_reg, p0_reg, span_reg;

    logic [31:0] est_reg [4];
    logic [31:0] meas_reg [4];
    logic [31:0] var_reg;
    logic [47:0] last_reg;
    logic [15:0] conf_reg;

    logic [47:0] now_reg;
    logic [47:0] elapsed_reg;
    logic [31:0] pp_reg;
    logic [F:0]  k_reg;
    logic [PW-1:0] prod_reg;
    logic [2:0]  cnt_reg;
    logic        expired_reg;
    logic        m_valid_reg;

    logic          div_done;
    logic [QW-1:0] div_quot;

    logic                 accept;
    logic [32:0]          pp_sum;
    logic [32:0]          den;
    logic [31:0]          span_eff;
    logic                 time_back;
    logic                 past_span;
    logic [1:0]           idx;
    logic signed [32:0]   diff;
    logic signed [33:0]   mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] delta;
    logic signed [PW-1:0] est_sum;
    logic [31:0]          est_sat;
    logic [PW-1:0]        var_shift;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == btks_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // shared datapath pieces
    always_comb begin
        pp_sum    = {1'b0, var_reg} + {1'b0, q_reg};
        den       = {1'b0, pp_reg} + {1'b0, r_reg};
        span_eff  = (span_reg == '0) ? 32'd1 : span_reg;
        time_back = now_reg < last_reg;
        past_span = elapsed_reg >= {16'd0, span_eff};
        idx       = cnt_reg[1:0];
        diff      = $signed({meas_reg[idx][31], meas_reg[idx]})
                  - $signed({est_reg[idx][31], est_reg[idx]});
        if (cnt_reg == 3'd4) begin
            mul_a = $signed({2'b00, pp_reg});
            mul_b = $signed({1'b0, K_ONE - k_reg});
        end else begin
            mul_a = {diff[32], diff};
            mul_b = $signed({1'b0, k_reg});
        end
        mul_p     = mul_a * mul_b;
        delta     = $signed(prod_reg + HALF) >>> F;
        est_sum   = $signed({{(PW-32){est_reg[idx][31]}}, est_reg[idx]}) + delta;
        if (est_sum[PW-1:31] == '0 || est_sum[PW-1:31] == '1) begin
            est_sat = est_sum[31:0];
        end else if (est_sum[PW-1]) begin
            est_sat = 32'h8000_0000;
        end else begin
            est_sat = 32'h7FFF_FFFF;
        end
        var_shift = prod_reg >> F;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btks_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        div_req          = '0;
        unique case (state_reg)
            btks_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (btks_pkg::op_t'(s_operation))
                        btks_pkg::OP_UPDATE: state_next = btks_pkg::ST_PRED;
                        btks_pkg::OP_AGE:    state_next = btks_pkg::ST_AGE;
                        default:             state_next = btks_pkg::ST_DONE;
                    endcase
                end
            end
            btks_pkg::ST_PRED: begin
                state_next = btks_pkg::ST_GAIN;
            end
            btks_pkg::ST_GAIN: begin
                if (den == '0) begin
                    state_next = btks_pkg::ST_MUL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {2'b00, pp_reg};
                    div_req.divisor  = den;
                    div_req.steps    = btks_pkg::DIV_CNT_W'(F + 1);
                    state_next       = btks_pkg::ST_DIV;
                end
            end
            btks_pkg::ST_AGE: begin
                state_next = time_back ? btks_pkg::ST_DONE : btks_pkg::ST_AGE_DIV;
            end
            btks_pkg::ST_AGE_DIV: begin
                if (past_span) begin
                    state_next = btks_pkg::ST_DONE;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = {1'b0, elapsed_reg[31:0], 1'b0};
                    div_req.divisor  = {1'b0, span_eff};
                    div_req.steps    = btks_pkg::CONF_DIV_STEPS;
                    state_next       = btks_pkg::ST_DIV;
                end
            end
            btks_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = (op_reg == btks_pkg::OP_UPDATE) ? btks_pkg::ST_MUL
                                                                 : btks_pkg::ST_DONE;
                end
            end
            btks_pkg::ST_MUL: begin
                state_next = btks_pkg::ST_ACC;
            end
            btks_pkg::ST_ACC: begin
                state_next = (cnt_reg == 3'd4) ? btks_pkg::ST_DONE : btks_pkg::ST_MUL;
            end
            btks_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = btks_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = btks_pkg::ST_IDLE;
            end
        endcase
    end

    btks_div #(
        .QW (QW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // configuration, filter state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg       <= btks_pkg::PROCESS_NOISE_RST;
            r_reg       <= btks_pkg::MEASUREMENT_NOISE_RST;
            p0_reg      <= btks_pkg::INITIAL_COVARIANCE_RST;
            span_reg    <= btks_pkg::EXPIRY_SPAN_RST;
            for (int i = 0; i < 4; i++) begin
                est_reg[i] <= '0;
            end
            var_reg     <= '0;
            last_reg    <= '0;
            conf_reg    <= btks_pkg::CONF_ONE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    btks_pkg::CFG_PROCESS_NOISE:      q_reg    <= cfg_data;
                    btks_pkg::CFG_MEASUREMENT_NOISE:  r_reg    <= cfg_data;
                    btks_pkg::CFG_INITIAL_COVARIANCE: p0_reg   <= cfg_data;
                    btks_pkg::CFG_EXPIRY_SPAN:        span_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                cnt_reg <= '0;
                if (btks_pkg::op_t'(s_operation) == btks_pkg::OP_START) begin
                    est_reg[0] <= s_meas_left_x;
                    est_reg[1] <= s_meas_left_y;
                    est_reg[2] <= s_meas_right_x;
                    est_reg[3] <= s_meas_right_y;
                    var_reg    <= p0_reg;
                    last_reg   <= s_time_now;
                    conf_reg   <= btks_pkg::CONF_ONE;
                end else if (btks_pkg::op_t'(s_operation) == btks_pkg::OP_UPDATE) begin
                    last_reg <= s_time_now;
                end
            end
            if (state_reg == btks_pkg::ST_AGE_DIV && past_span) begin
                conf_reg <= '0;
            end
            if (state_reg == btks_pkg::ST_DIV && div_done && op_reg == btks_pkg::OP_AGE) begin
                conf_reg <= btks_pkg::CONF_ONE - {1'b0, div_quot[14:0]};
            end
            if (state_reg == btks_pkg::ST_ACC) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    var_reg <= var_shift[31:0];
                end else begin
                    est_reg[idx] <= est_sat;
                end
            end
            if (state_reg == btks_pkg::ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item working registers and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg      <= btks_pkg::op_t'(s_operation);
            meas_reg[0] <= s_meas_left_x;
            meas_reg[1] <= s_meas_left_y;
            meas_reg[2] <= s_meas_right_x;
            meas_reg[3] <= s_meas_right_y;
            now_reg     <= s_time_now;
            expired_reg <= 1'b0;
        end
        if (state_reg == btks_pkg::ST_PRED) begin
            pp_reg <= pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
        end
        if (state_reg == btks_pkg::ST_GAIN) begin
            k_reg <= '0;
        end
        if (state_reg == btks_pkg::ST_DIV && div_done) begin
            k_reg <= div_quot[F:0];
        end
        if (state_reg == btks_pkg::ST_AGE) begin
            elapsed_reg <= now_reg - last_reg;
            if (time_back) begin
                expired_reg <= 1'b1;
            end
        end
        if (state_reg == btks_pkg::ST_AGE_DIV && past_span) begin
            expired_reg <= elapsed_reg != {16'd0, span_eff};
        end
        if (state_reg == btks_pkg::ST_MUL) begin
            prod_reg <= mul_p;
        end
        if (state_reg == btks_pkg::ST_DONE && (!m_valid_reg || m_ready)) begin
            m_est_left_x     <= est_reg[0];
            m_est_left_y     <= est_reg[1];
            m_est_right_x    <= est_reg[2];
            m_est_right_y    <= est_reg[3];
            m_error_variance <= var_reg;
            m_confidence     <= conf_reg;
            m_expired        <= expired_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_conf_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_confidence <= btks_pkg::CONF_ONE)
        else $error("confidence above one");

    a_gain_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == btks_pkg::ST_MUL |-> k_reg <= K_ONE)
        else $error("gain above one");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg
            && $stable({m_est_left_x, m_est_left_y, m_est_right_x, m_est_right_y,
                        m_error_variance, m_confidence, m_expired}))
        else $error("waiting result item changed");

endmodule

`default_nettype wire

@@ design/btks_div.sv @@
`default_nettype none

module btks_div #(
    parameter int QW = 17
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire btks_pkg::div_req_t req,
    output logic                   done,
    output logic [QW-1:0]          quot
);

    logic [btks_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [btks_pkg::DIVISOR_W-1:0] div_reg;
    logic [QW-1:0]                  quot_reg, quot_next;
    logic [btks_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           ge;
    logic [btks_pkg::REM_W-1:0]     rem_sub;

    // one restoring step: compare, subtract, shift
    always_comb begin
        ge        = rem_reg >= {1'b0, div_reg};
        rem_sub   = ge ? (rem_reg - {1'b0, div_reg}) : rem_reg;
        rem_next  = {rem_sub[btks_pkg::REM_W-2:0], 1'b0};
        quot_next = {quot_reg[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == btks_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.rem_init;
            div_reg  <= req.divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    a_no_start_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (req.divisor != '0) && (req.steps != '0))
        else $error("divider started with zero divisor or no steps");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");

endmodule

`default_nettype wire
